// ----- sv/lgps_pkg.sv -----
`timescale 1ns / 1ps

package lgps_pkg;

    // fixed field widths
    localparam int POS_W   = 17;
    localparam int CH_W    = 8;
    localparam int IDX_W   = 3;
    localparam int BOX_W   = 13;
    localparam int DIR_W   = 16;
    localparam int CNT_W   = 4;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    // t in unsigned q1.16
    localparam logic [POS_W-1:0] T_ZERO = 17'd0;
    localparam logic [POS_W-1:0] T_HALF = 17'd32768;
    localparam logic [POS_W-1:0] T_ONE  = 17'd65536;

    localparam logic [BOX_W-1:0] BOX_DEFAULT = 13'd100;

    // command codes
    localparam logic CMD_STOP  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_BOX_WIDTH  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_BOX_HEIGHT = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_DIR_X      = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_DIR_Y      = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_STOP_COUNT = 3'd4;

    // how t is formed after the divider
    typedef enum logic [1:0] {
        TSEL_QUOT,
        TSEL_HALF,
        TSEL_ZERO,
        TSEL_ONE
    } t_tsel;

    typedef logic [3:0][CH_W-1:0] t_rgba;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             given;
        t_rgba            ch;
    } t_stop;

endpackage

// ----- sv/lgps_cfg_if.sv -----
`timescale 1ns / 1ps

interface lgps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lgps_pkg::CFG_A_W-1:0]  index;
    logic [lgps_pkg::CFG_D_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/lgps_in_if.sv -----
`timescale 1ns / 1ps

interface lgps_in_if #(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [COORD_BITS-1:0]         pixel_x;
    logic [COORD_BITS-1:0]         pixel_y;
    logic [lgps_pkg::IDX_W-1:0]    stop_index;
    logic [lgps_pkg::POS_W-1:0]    stop_position;
    logic                          stop_position_given;
    logic [lgps_pkg::CH_W-1:0]     stop_red;
    logic [lgps_pkg::CH_W-1:0]     stop_green;
    logic [lgps_pkg::CH_W-1:0]     stop_blue;
    logic [lgps_pkg::CH_W-1:0]     stop_alpha;

    modport source (
        output valid, output command, output pixel_x, output pixel_y,
        output stop_index, output stop_position, output stop_position_given,
        output stop_red, output stop_green, output stop_blue, output stop_alpha,
        input ready
    );
    modport sink (
        input valid, input command, input pixel_x, input pixel_y,
        input stop_index, input stop_position, input stop_position_given,
        input stop_red, input stop_green, input stop_blue, input stop_alpha,
        output ready
    );
endinterface

// ----- sv/lgps_out_if.sv -----
`timescale 1ns / 1ps

interface lgps_out_if;
    logic                       valid;
    logic                       ready;
    logic [lgps_pkg::CH_W-1:0]  out_red;
    logic [lgps_pkg::CH_W-1:0]  out_green;
    logic [lgps_pkg::CH_W-1:0]  out_blue;
    logic [lgps_pkg::CH_W-1:0]  out_alpha;

    modport source (
        output valid, output out_red, output out_green, output out_blue,
        output out_alpha, input ready
    );
    modport sink (
        input valid, input out_red, input out_green, input out_blue,
        input out_alpha, output ready
    );
endinterface

// ----- sv/linear_gradient_pixel_shader.sv -----
`timescale 1ns / 1ps

// channel   dir  transfer when         carries
// i_cfg     in   valid && ready        register index, write data
// i_in      in   valid && ready        stop load or pixel coordinates
// o_out     out  valid && ready        shaded rgba pixel
//
// one item per cycle while the output is not held
// the pipe depth is mostly the 16 stage t divider and the 8 stage mix divider
// stop loads give no result and update the stop table 21 stages in, so
// every later pixel sees them in order
// one pipeline enable: when the result is held the whole pipe holds
// synchronous active low reset: valid bits clear, config defaults, no stops

module linear_gradient_pixel_shader #(
    parameter int MAX_STOPS  = 8,
    parameter int COORD_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lgps_cfg_if.sink      i_cfg,
    lgps_in_if.sink       i_in,
    lgps_out_if.source    o_out
);

    localparam int CW = $clog2(MAX_STOPS + 1);
    // signed 2x - w
    localparam int SW = ((COORD_BITS + 1 > lgps_pkg::BOX_W) ?
                         COORD_BITS + 1 : lgps_pkg::BOX_W) + 1;
    localparam int PW = SW + lgps_pkg::DIR_W;
    localparam int NW = ((PW > 31) ? PW : 31) + 2;
    localparam int TD = 16;  // t divider stages, one quotient bit each
    localparam int MD = 8;   // mix divider stages
    localparam int MW = 28;  // signed mix numerator
    localparam int RW = 27;  // mix remainder

    // ---------------- configuration registers ----------------
    logic [lgps_pkg::BOX_W-1:0]        r_box_w;
    logic [lgps_pkg::BOX_W-1:0]        r_box_h;
    logic signed [lgps_pkg::DIR_W-1:0] r_dir_x;
    logic signed [lgps_pkg::DIR_W-1:0] r_dir_y;
    logic [lgps_pkg::CNT_W-1:0]        r_stop_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w      <= lgps_pkg::BOX_DEFAULT;
            r_box_h      <= lgps_pkg::BOX_DEFAULT;
            r_dir_x      <= 16'sd32767;
            r_dir_y      <= 16'sd0;
            r_stop_count <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lgps_pkg::REG_BOX_WIDTH:  r_box_w      <= i_cfg.data[lgps_pkg::BOX_W-1:0];
                lgps_pkg::REG_BOX_HEIGHT: r_box_h      <= i_cfg.data[lgps_pkg::BOX_W-1:0];
                lgps_pkg::REG_DIR_X:      r_dir_x      <= $signed(i_cfg.data);
                lgps_pkg::REG_DIR_Y:      r_dir_y      <= $signed(i_cfg.data);
                lgps_pkg::REG_STOP_COUNT: r_stop_count <= i_cfg.data[lgps_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    logic r_out_vld;
    logic en;
    logic acc;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;
    assign acc        = i_in.valid && en;

    // ---------------- stage 1: products ----------------
    typedef struct packed {
        logic                 vld;
        logic                 cmd;
        logic [lgps_pkg::IDX_W-1:0] idx;
        lgps_pkg::t_stop      stp;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic [29:0]          ax;
        logic [29:0]          ay;
    } t_s1;

    t_s1 r_s1, n_s1;

    logic [lgps_pkg::BOX_W-1:0] w_eff, h_eff;
    logic signed [SW-1:0]       sx, sy;
    logic signed [16:0]         dxe, dye;
    logic [16:0]                ux, uy;

    always_comb begin
        w_eff = (r_box_w == '0) ? lgps_pkg::BOX_DEFAULT : r_box_w;
        h_eff = (r_box_h == '0) ? lgps_pkg::BOX_DEFAULT : r_box_h;
        sx    = $signed(SW'({i_in.pixel_x, 1'b0})) - $signed(SW'(w_eff));
        sy    = $signed(SW'({i_in.pixel_y, 1'b0})) - $signed(SW'(h_eff));
        dxe   = 17'(r_dir_x);
        dye   = 17'(r_dir_y);
        ux    = dxe[16] ? 17'(-dxe) : 17'(dxe);
        uy    = dye[16] ? 17'(-dye) : 17'(dye);

        n_s1.vld          = acc;
        n_s1.cmd          = i_in.command;
        n_s1.idx          = i_in.stop_index;
        n_s1.stp.pos      = i_in.stop_position;
        n_s1.stp.given    = i_in.stop_position_given;
        n_s1.stp.ch[0]    = i_in.stop_red;
        n_s1.stp.ch[1]    = i_in.stop_green;
        n_s1.stp.ch[2]    = i_in.stop_blue;
        n_s1.stp.ch[3]    = i_in.stop_alpha;
        n_s1.px           = PW'(sx) * PW'(r_dir_x);
        n_s1.py           = PW'(sy) * PW'(r_dir_y);
        n_s1.ax           = 30'(ux) * 30'(w_eff);
        n_s1.ay           = 30'(uy) * 30'(h_eff);
    end

    // ---------------- stage 2: projection and half extent ----------------
    typedef struct packed {
        logic                 vld;
        logic                 cmd;
        logic [lgps_pkg::IDX_W-1:0] idx;
        lgps_pkg::t_stop      stp;
        logic signed [NW-1:0] n;
        logic [30:0]          e;
    } t_s2;

    t_s2 r_s2, n_s2;

    always_comb begin
        n_s2.vld = r_s1.vld;
        n_s2.cmd = r_s1.cmd;
        n_s2.idx = r_s1.idx;
        n_s2.stp = r_s1.stp;
        n_s2.n   = NW'(r_s1.px) + NW'(r_s1.py);
        n_s2.e   = 31'(r_s1.ax) + 31'(r_s1.ay);
    end

    // ---------------- stage 3 and t divider stages ----------------
    typedef struct packed {
        logic                 vld;
        logic                 cmd;
        logic [lgps_pkg::IDX_W-1:0] idx;
        lgps_pkg::t_stop      stp;
        lgps_pkg::t_tsel      tsel;
        logic [31:0]          rem;
        logic [31:0]          dv;
        logic [TD-1:0]        q;
    } t_dv;

    t_dv r_s3, n_s3;
    t_dv r_dv [TD];
    t_dv n_dv [TD];

    logic signed [NW-1:0] a_num;
    logic signed [NW-1:0] d_sg;

    always_comb begin
        a_num    = r_s2.n + $signed(NW'(r_s2.e));
        d_sg     = $signed(NW'({r_s2.e, 1'b0}));
        n_s3.vld = r_s2.vld;
        n_s3.cmd = r_s2.cmd;
        n_s3.idx = r_s2.idx;
        n_s3.stp = r_s2.stp;
        n_s3.dv  = 32'({r_s2.e, 1'b0});
        n_s3.rem = a_num[31:0];
        n_s3.q   = '0;
        // zero direction, below start, past end
        if (r_s2.e == '0) begin
            n_s3.tsel = lgps_pkg::TSEL_HALF;
        end else if (a_num <= 0) begin
            n_s3.tsel = lgps_pkg::TSEL_ZERO;
        end else if (a_num >= d_sg) begin
            n_s3.tsel = lgps_pkg::TSEL_ONE;
        end else begin
            n_s3.tsel = lgps_pkg::TSEL_QUOT;
        end
    end

    // restoring division, remainder stays below the divisor
    logic [31:0] dv_sh [TD];

    always_comb begin
        for (int k = 0; k < TD; k++) begin
            n_dv[k]  = (k == 0) ? r_s3 : r_dv[(k == 0) ? 0 : k - 1];
            dv_sh[k] = {n_dv[k].rem[30:0], 1'b0};
            if (dv_sh[k] >= n_dv[k].dv) begin
                n_dv[k].rem = dv_sh[k] - n_dv[k].dv;
                n_dv[k].q   = {n_dv[k].q[TD-2:0], 1'b1};
            end else begin
                n_dv[k].rem = dv_sh[k];
                n_dv[k].q   = {n_dv[k].q[TD-2:0], 1'b0};
            end
        end
    end

    // ---------------- t stage ----------------
    typedef struct packed {
        logic                 vld;
        logic                 cmd;
        logic [lgps_pkg::IDX_W-1:0] idx;
        lgps_pkg::t_stop      stp;
        logic [lgps_pkg::POS_W-1:0] t;
    } t_ts;

    t_ts r_t, n_t;

    always_comb begin
        n_t.vld = r_dv[TD-1].vld;
        n_t.cmd = r_dv[TD-1].cmd;
        n_t.idx = r_dv[TD-1].idx;
        n_t.stp = r_dv[TD-1].stp;
        case (r_dv[TD-1].tsel)
            lgps_pkg::TSEL_HALF: n_t.t = lgps_pkg::T_HALF;
            lgps_pkg::TSEL_ZERO: n_t.t = lgps_pkg::T_ZERO;
            lgps_pkg::TSEL_ONE:  n_t.t = lgps_pkg::T_ONE;
            default:             n_t.t = {1'b0, r_dv[TD-1].q};
        endcase
    end

    // ---------------- lookup stage: stop table read and write ----------------
    lgps_pkg::t_stop r_tbl [MAX_STOPS];

    typedef struct packed {
        logic                       vld;
        logic [lgps_pkg::POS_W-1:0] t;
        logic                       cnt0;
        logic                       found;
        logic [lgps_pkg::POS_W-1:0] p0;
        logic [lgps_pkg::POS_W-1:0] p1;
        lgps_pkg::t_rgba            c0;
        lgps_pkg::t_rgba            c1;
        lgps_pkg::t_rgba            last;
    } t_l1;

    t_l1 r_l1, n_l1;

    logic [CW-1:0]              cnt;
    logic [lgps_pkg::POS_W-1:0] sp0, sp1;

    always_comb begin
        // stop count saturates at the table size
        cnt = (32'(r_stop_count) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(r_stop_count);
        n_l1.vld   = r_t.vld && (r_t.cmd == lgps_pkg::CMD_PIXEL);
        n_l1.t     = r_t.t;
        n_l1.cnt0  = (cnt == '0);
        n_l1.found = 1'b0;
        n_l1.p0    = '0;
        n_l1.p1    = '0;
        n_l1.c0    = '0;
        n_l1.c1    = '0;
        n_l1.last  = '0;
        sp0        = '0;
        sp1        = '0;
        // descending so the first matching segment wins
        for (int i = MAX_STOPS - 2; i >= 0; i--) begin
            if (r_tbl[i].given) begin
                sp0 = r_tbl[i].pos;
            end else begin
                sp0 = (i == 0) ? lgps_pkg::T_ZERO : lgps_pkg::T_ONE;
            end
            sp1 = r_tbl[i + 1].given ? r_tbl[i + 1].pos : lgps_pkg::T_ONE;
            if ((i + 1 < int'(cnt)) && (r_t.t >= sp0) && (r_t.t <= sp1)) begin
                n_l1.found = 1'b1;
                n_l1.p0    = sp0;
                n_l1.p1    = sp1;
                n_l1.c0    = r_tbl[i].ch;
                n_l1.c1    = r_tbl[i + 1].ch;
            end
        end
        for (int j = 0; j < MAX_STOPS; j++) begin
            if (j + 1 == int'(cnt)) begin
                n_l1.last = r_tbl[j].ch;
            end
        end
    end

    // stop load lands here, in order with the pixels around it
    always_ff @(posedge i_clk) begin
        if (en && r_t.vld && (r_t.cmd == lgps_pkg::CMD_STOP)) begin
            for (int j = 0; j < MAX_STOPS; j++) begin
                if (32'(r_t.idx) == j) begin
                    r_tbl[j] <= r_t.stp;
                end
            end
        end
    end

    // ---------------- mode stage ----------------
    typedef struct packed {
        logic                       vld;
        logic                       mix;
        lgps_pkg::t_rgba            direct;
        logic [lgps_pkg::POS_W-1:0] rng;
        logic [lgps_pkg::POS_W-1:0] d;
        lgps_pkg::t_rgba            c0;
        lgps_pkg::t_rgba            c1;
    } t_l2;

    t_l2 r_l2, n_l2;

    logic [24:0]          grey_w;
    lgps_pkg::t_rgba      half;

    always_comb begin
        grey_w = (25'(r_l1.t) * 25'd255) >> 16;
        for (int k = 0; k < 4; k++) begin
            half[k] = 8'((9'(r_l1.c0[k]) + 9'(r_l1.c1[k]) + 9'd1) >> 1);
        end
        n_l2.vld = r_l1.vld;
        n_l2.rng = r_l1.p1 - r_l1.p0;
        n_l2.d   = r_l1.t - r_l1.p0;
        n_l2.c0  = r_l1.c0;
        n_l2.c1  = r_l1.c1;
        n_l2.mix = 1'b0;
        if (r_l1.cnt0) begin
            n_l2.direct = {8'd255, grey_w[7:0], grey_w[7:0], grey_w[7:0]};
        end else if (!r_l1.found) begin
            n_l2.direct = r_l1.last;
        end else if (r_l1.p1 <= r_l1.p0) begin
            // empty segment takes the midpoint
            n_l2.direct = half;
        end else begin
            n_l2.direct = '0;
            n_l2.mix    = 1'b1;
        end
    end

    // ---------------- mix numerator stage ----------------
    typedef struct packed {
        logic                       vld;
        logic                       mix;
        lgps_pkg::t_rgba            direct;
        logic [lgps_pkg::POS_W-1:0] rng;
        logic [3:0][RW-2:0]         m;
    } t_l3;

    t_l3 r_l3, n_l3;

    logic signed [8:0]    df [4];
    logic signed [MW-1:0] msum [4];

    always_comb begin
        n_l3.vld    = r_l2.vld;
        n_l3.mix    = r_l2.mix;
        n_l3.direct = r_l2.direct;
        n_l3.rng    = r_l2.rng;
        for (int k = 0; k < 4; k++) begin
            df[k]     = $signed({1'b0, r_l2.c1[k]}) - $signed({1'b0, r_l2.c0[k]});
            msum[k]   = $signed(MW'(r_l2.c0[k])) * $signed(MW'(r_l2.rng))
                      + MW'(df[k]) * $signed(MW'(r_l2.d));
            n_l3.m[k] = msum[k][RW-2:0];
        end
    end

    // ---------------- mix divider ----------------
    typedef struct packed {
        logic                       vld;
        logic                       mix;
        lgps_pkg::t_rgba            direct;
        logic [lgps_pkg::POS_W:0]   dm;
        logic [3:0][RW-1:0]         rem;
        lgps_pkg::t_rgba            q;
    } t_md;

    t_md r_l4, n_l4;
    t_md r_md [MD];
    t_md n_md [MD];

    logic [RW-1:0] md_sh [MD];

    always_comb begin
        n_l4.vld    = r_l3.vld;
        n_l4.mix    = r_l3.mix;
        n_l4.direct = r_l3.direct;
        n_l4.dm     = {r_l3.rng, 1'b0};
        n_l4.q      = '0;
        // round half up: (2m + range) / (2 range)
        for (int k = 0; k < 4; k++) begin
            n_l4.rem[k] = {r_l3.m[k], 1'b0} + RW'(r_l3.rng);
        end
    end

    always_comb begin
        for (int s = 0; s < MD; s++) begin
            n_md[s]  = (s == 0) ? r_l4 : r_md[(s == 0) ? 0 : s - 1];
            md_sh[s] = RW'(n_md[s].dm) << (MD - 1 - s);
            for (int k = 0; k < 4; k++) begin
                if (n_md[s].rem[k] >= md_sh[s]) begin
                    n_md[s].rem[k]          = n_md[s].rem[k] - md_sh[s];
                    n_md[s].q[k][MD - 1 - s] = 1'b1;
                end
            end
        end
    end

    // ---------------- output register ----------------
    lgps_pkg::t_rgba r_out;

    assign o_out.valid     = r_out_vld;
    assign o_out.out_red   = r_out[0];
    assign o_out.out_green = r_out[1];
    assign o_out.out_blue  = r_out[2];
    assign o_out.out_alpha = r_out[3];

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld  <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_s3.vld  <= 1'b0;
            for (int k = 0; k < TD; k++) begin
                r_dv[k].vld <= 1'b0;
            end
            r_t.vld   <= 1'b0;
            r_l1.vld  <= 1'b0;
            r_l2.vld  <= 1'b0;
            r_l3.vld  <= 1'b0;
            r_l4.vld  <= 1'b0;
            for (int s = 0; s < MD; s++) begin
                r_md[s].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            for (int k = 0; k < TD; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_t  <= n_t;
            r_l1 <= n_l1;
            r_l2 <= n_l2;
            r_l3 <= n_l3;
            r_l4 <= n_l4;
            for (int s = 0; s < MD; s++) begin
                r_md[s] <= n_md[s];
            end
            r_out_vld <= r_md[MD-1].vld;
            r_out     <= r_md[MD-1].mix ? r_md[MD-1].q : r_md[MD-1].direct;
        end
    end

    // ---------------- assertions ----------------
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input not ready with output empty");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t.vld |-> (r_t.t <= lgps_pkg::T_ONE))
        else $error("t above one");

    a_mix_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_md[MD-1].vld && r_md[MD-1].mix) |->
            ((r_md[MD-1].rem[0] < RW'(r_md[MD-1].dm)) &&
             (r_md[MD-1].rem[1] < RW'(r_md[MD-1].dm)) &&
             (r_md[MD-1].rem[2] < RW'(r_md[MD-1].dm)) &&
             (r_md[MD-1].rem[3] < RW'(r_md[MD-1].dm))))
        else $error("mix quotient overflow");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_out)))
        else $error("result lost under stall");

endmodule
